/* hdl/sgm_pkg.sv */
// sgm_pkg: shared types and constants of the Sobel gradient magnitude block.
// Used by sgm_magnitude and sobel_gradient_magnitude; depends on nothing.

package sgm_pkg;

  localparam int PIX_W      = 8;
  localparam int CRD_W      = 11;
  localparam int GEOM_W     = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 36;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_X     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_Y     = 2'd3;

  localparam logic [GEOM_W-1:0]     WIDTH_RESET  = 12'd640;
  localparam logic [GEOM_W-1:0]     HEIGHT_RESET = 12'd480;
  localparam logic [GEOM_W-1:0]     ROW_LIMIT    = 12'd2048;
  // Sobel X: -1 0 1 / -2 0 2 / -1 0 1, Sobel Y: -1 -2 -1 / 0 0 0 / 1 2 1
  localparam logic [CFG_DATA_W-1:0] KX_RESET     = 36'h10F20E10F;
  localparam logic [CFG_DATA_W-1:0] KY_RESET     = 36'h121000FEF;

  // 3x3 window, entry row*3+col, row 0 oldest, col 0 leftmost
  typedef logic [8:0][PIX_W-1:0] win_t;

  typedef struct packed {
    logic [CRD_W-1:0] col;
    logic [CRD_W-1:0] row;
    logic             last;
  } tag_t;

endpackage

/* hdl/sgm_ram.sv */
// sgm_ram: generic single-port-write, single-port-read RAM with registered read.
// Stand-alone; no package needed.

module sgm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/sgm_magnitude.sv */
// sgm_magnitude: six-stage pipeline from a 3x3 window to the saturated
// gradient magnitude. Depends on sgm_pkg (win_t, tag_t).

module sgm_magnitude #(
  parameter int COEF_BITS = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_valid,
  input  sgm_pkg::win_t            win,
  input  sgm_pkg::tag_t            tag_in,
  input  logic [9*COEF_BITS-1:0]   kx,
  input  logic [9*COEF_BITS-1:0]   ky,
  output logic                     out_valid,
  output logic [sgm_pkg::PIX_W-1:0] out_mag,
  output sgm_pkg::tag_t            out_tag
);

  localparam int PW = COEF_BITS + 9;   // coefficient times pixel
  localparam int RW = COEF_BITS + 11;  // sum of one kernel row
  localparam int GW = COEF_BITS + 12;  // full gradient

  typedef struct packed {
    logic [10:0] rem;
    logic [7:0]  root;
  } sqrt_t;

  // four digit-by-digit square root steps on two bits each
  function automatic sqrt_t sqrt_step4(input logic [10:0] rem_i, input logic [7:0] root_i,
                                       input logic [7:0] bits);
    logic [10:0] rem;
    logic [7:0]  root;
    logic [10:0] test;
    sqrt_t       res;
    rem  = rem_i;
    root = root_i;
    for (int i = 0; i < 4; i++) begin
      rem  = {rem[8:0], bits[7-2*i -: 2]};
      test = {1'b0, root, 2'b01};
      if (rem >= test) begin
        rem  = rem - test;
        root = {root[6:0], 1'b1};
      end else begin
        root = {root[6:0], 1'b0};
      end
    end
    res.rem  = rem;
    res.root = root;
    return res;
  endfunction

  logic va_r, vb_r, vc_r, vd_r, ve_r, vf_r;

  sgm_pkg::win_t win_a_r;
  sgm_pkg::tag_t tag_a_r, tag_b_r, tag_c_r, tag_d_r, tag_e_r, tag_f_r;

  logic signed [PW-1:0] prod_x [9];
  logic signed [PW-1:0] prod_y [9];
  logic signed [RW-1:0] rx_nxt [3];
  logic signed [RW-1:0] ry_nxt [3];
  logic signed [RW-1:0] rx_b_r [3];
  logic signed [RW-1:0] ry_b_r [3];

  logic signed [GW-1:0] gx, gy;
  logic [GW-1:0]        ax_full, ay_full;
  logic [7:0]           ax_c_r, ay_c_r;
  logic                 sat_c_r;

  logic [15:0] sqx_d_r, sqy_d_r;
  logic        sat_d_r;

  logic [16:0] sum_sq;
  sqrt_t       sq_hi, sq_lo;
  logic [10:0] rem_e_r;
  logic [7:0]  root_e_r;
  logic [7:0]  low_e_r;
  logic        sat_e_r;

  logic [7:0]  mag_f_r;

  // products and row sums
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      prod_x[k] = $signed(kx[COEF_BITS*k +: COEF_BITS]) * $signed({1'b0, win_a_r[k]});
      prod_y[k] = $signed(ky[COEF_BITS*k +: COEF_BITS]) * $signed({1'b0, win_a_r[k]});
    end
    for (int i = 0; i < 3; i++) begin
      rx_nxt[i] = RW'(prod_x[3*i]) + RW'(prod_x[3*i+1]) + RW'(prod_x[3*i+2]);
      ry_nxt[i] = RW'(prod_y[3*i]) + RW'(prod_y[3*i+1]) + RW'(prod_y[3*i+2]);
    end
  end

  // gradients, absolute value; anything at or above 256 saturates
  always_comb begin
    gx      = GW'(rx_b_r[0]) + GW'(rx_b_r[1]) + GW'(rx_b_r[2]);
    gy      = GW'(ry_b_r[0]) + GW'(ry_b_r[1]) + GW'(ry_b_r[2]);
    ax_full = gx[GW-1] ? GW'(-gx) : GW'(gx);
    ay_full = gy[GW-1] ? GW'(-gy) : GW'(gy);
  end

  assign sum_sq = {1'b0, sqx_d_r} + {1'b0, sqy_d_r};
  assign sq_hi  = sqrt_step4(11'd0, 8'd0, sum_sq[15:8]);
  assign sq_lo  = sqrt_step4(rem_e_r, root_e_r, low_e_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      win_a_r  <= win;
      tag_a_r  <= tag_in;
      rx_b_r   <= rx_nxt;
      ry_b_r   <= ry_nxt;
      tag_b_r  <= tag_a_r;
      ax_c_r   <= ax_full[7:0];
      ay_c_r   <= ay_full[7:0];
      sat_c_r  <= (|ax_full[GW-1:8]) | (|ay_full[GW-1:8]);
      tag_c_r  <= tag_b_r;
      sqx_d_r  <= ax_c_r * ax_c_r;
      sqy_d_r  <= ay_c_r * ay_c_r;
      sat_d_r  <= sat_c_r;
      tag_d_r  <= tag_c_r;
      rem_e_r  <= sq_hi.rem;
      root_e_r <= sq_hi.root;
      low_e_r  <= sum_sq[7:0];
      sat_e_r  <= sat_d_r | sum_sq[16];
      tag_e_r  <= tag_d_r;
      mag_f_r  <= sat_e_r ? 8'hFF : sq_lo.root;
      tag_f_r  <= tag_e_r;
    end
  end

  assign out_valid = vf_r;
  assign out_mag   = mag_f_r;
  assign out_tag   = tag_f_r;

  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable({va_r, vb_r, vc_r, vd_r, ve_r, vf_r}))
    else $error("pipeline valid bits moved while stalled");

  a_sqrt_remainder: assert property (@(posedge clk) disable iff (!rst_n)
    ve_r |-> (rem_e_r <= {2'b00, root_e_r, 1'b0}))
    else $error("square root remainder out of range");

  a_valid_advance: assert property (@(posedge clk) disable iff (!rst_n)
    en && ve_r |=> vf_r)
    else $error("request lost between last two stages");

endmodule

/* hdl/sobel_gradient_magnitude.sv */
// sobel_gradient_magnitude: top level of the 3x3 Sobel edge detector.
// Depends on sgm_pkg, sgm_ram (line stores) and sgm_magnitude (arithmetic).
//
// Usage:
//   in_valid/in_ready/in_pixel carry 8-bit grayscale pixels in raster order,
//   row 0 column 0 first. out_valid/out_ready carry one result per interior
//   pixel: magnitude, its column and row, and a mark on the last one of the
//   image. Border positions and images narrower or shorter than 3 give none.
//   cfg_we/cfg_index/cfg_data write image width, image height and the two
//   packed kernels; write only while no request is in flight.
//   Throughput is one pixel per clock while in_ready is high, set by the line
//   store memory, which takes one read and one write of both stored rows per
//   cycle. A result passes the line store read, then six arithmetic stages
//   (window, products and row sums, gradient, squares, two root stages), then
//   the output register.
//   Reset restores 640x480 and the Sobel kernels and clears the position
//   counters and window; line store contents stay undefined, no clearing pass.
//   When out_ready is low the output register holds, a skid register takes
//   one more result, and only then in_ready drops and the pipeline freezes.

module sobel_gradient_magnitude #(
  parameter int MAX_WIDTH = 2048,
  parameter int COEF_BITS = 4
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [sgm_pkg::PIX_W-1:0]         in_pixel,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [sgm_pkg::PIX_W-1:0]         out_magnitude,
  output logic [sgm_pkg::CRD_W-1:0]         out_col,
  output logic [sgm_pkg::CRD_W-1:0]         out_row,
  output logic                              out_last_of_image,
  input  logic                              cfg_we,
  input  logic [sgm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LS_DEPTH = (MAX_WIDTH > 2048) ? 2048 : MAX_WIDTH;
  localparam int CW       = $clog2(LS_DEPTH);
  localparam int WW       = ($clog2(MAX_WIDTH + 1) > 12) ? $clog2(MAX_WIDTH + 1) : 12;
  localparam int KW       = 9 * COEF_BITS;
  localparam int PX       = sgm_pkg::PIX_W;
  localparam int KR       = sgm_pkg::CFG_DATA_W;

  logic [sgm_pkg::GEOM_W-1:0] width_r, height_r;
  logic [KR-1:0]              kernel_x_r, kernel_y_r;
  logic [KW+KR-1:0]           kx_pad, ky_pad;
  logic [KW-1:0]              kx_coefs, ky_coefs;

  logic [WW-1:0]              w_eff;
  logic [sgm_pkg::GEOM_W-1:0] h_eff;
  logic [CW-1:0]              col_cnt_r, col_nxt;
  logic [sgm_pkg::CRD_W-1:0]  row_cnt_r, row_nxt;
  logic                       row_end, img_end, emit, accept, en;
  sgm_pkg::tag_t              tag;

  logic                       s1_valid_r, s1_emit_r, fwd_r;
  logic [PX-1:0]              s1_px_r;
  logic [CW-1:0]              s1_col_r;
  sgm_pkg::tag_t              s1_tag_r;
  logic [2*PX-1:0]            fwd_data_r, ram_rdata, ram_wdata;
  logic [PX-1:0]              top_eff, mid_eff;
  logic [5:0][PX-1:0]         win_r;
  sgm_pkg::win_t              window;

  logic                       m_valid;
  logic [PX-1:0]              m_mag;
  sgm_pkg::tag_t              m_tag;

  logic                       out_valid_r, skid_valid_r, pop, push;
  logic [PX-1:0]              out_mag_r, skid_mag_r;
  sgm_pkg::tag_t              out_tag_r, skid_tag_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= sgm_pkg::WIDTH_RESET;
      height_r   <= sgm_pkg::HEIGHT_RESET;
      kernel_x_r <= sgm_pkg::KX_RESET;
      kernel_y_r <= sgm_pkg::KY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgm_pkg::CFG_IMAGE_WIDTH:  width_r    <= cfg_data[sgm_pkg::GEOM_W-1:0];
        sgm_pkg::CFG_IMAGE_HEIGHT: height_r   <= cfg_data[sgm_pkg::GEOM_W-1:0];
        sgm_pkg::CFG_KERNEL_X:     kernel_x_r <= cfg_data;
        sgm_pkg::CFG_KERNEL_Y:     kernel_y_r <= cfg_data;
      endcase
    end
  end

  // coefficients past the register's top bits read as zero
  assign kx_pad   = {{KW{1'b0}}, kernel_x_r};
  assign ky_pad   = {{KW{1'b0}}, kernel_y_r};
  assign kx_coefs = kx_pad[KW-1:0];
  assign ky_coefs = ky_pad[KW-1:0];

  // position tracking
  always_comb begin
    w_eff   = (WW'(width_r) > WW'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(width_r);
    h_eff   = (height_r > sgm_pkg::ROW_LIMIT) ? sgm_pkg::ROW_LIMIT : height_r;
    row_end = (WW'(col_cnt_r) + WW'(1)) >= w_eff;
    img_end = row_end && (({1'b0, row_cnt_r} + 12'd1) >= h_eff);
    emit    = (col_cnt_r >= CW'(2)) && (row_cnt_r >= 11'd2) &&
              (w_eff >= WW'(3)) && (h_eff >= 12'd3);
    col_nxt = row_end ? '0 : col_cnt_r + CW'(1);
    if (!row_end) begin
      row_nxt = row_cnt_r;
    end else if (img_end) begin
      row_nxt = '0;
    end else begin
      row_nxt = row_cnt_r + 11'd1;
    end
    tag.col  = sgm_pkg::CRD_W'(col_cnt_r) - 11'd1;
    tag.row  = row_cnt_r - 11'd1;
    tag.last = img_end;
  end

  assign en       = !skid_valid_r;
  assign in_ready = en;
  assign accept   = in_valid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_cnt_r <= '0;
      row_cnt_r <= '0;
    end else if (accept) begin
      col_cnt_r <= col_nxt;
      row_cnt_r <= row_nxt;
    end
  end

  // stage 1: line store read lands here
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      fwd_r      <= 1'b0;
    end else if (en) begin
      s1_valid_r <= in_valid;
      s1_emit_r  <= emit;
      // write and read of one column at the same edge: read data is stale
      fwd_r      <= s1_valid_r && (s1_col_r == col_cnt_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px_r    <= in_pixel;
      s1_col_r   <= col_cnt_r;
      s1_tag_r   <= tag;
      fwd_data_r <= ram_wdata;
    end
  end

  assign {top_eff, mid_eff} = fwd_r ? fwd_data_r : ram_rdata;
  assign ram_wdata          = {mid_eff, s1_px_r};

  sgm_ram #(
    .WIDTH (2 * PX),
    .DEPTH (LS_DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (en && s1_valid_r),
    .waddr (s1_col_r),
    .wdata (ram_wdata),
    .re    (en),
    .raddr (col_cnt_r),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r <= '0;
    end else if (en && s1_valid_r) begin
      win_r <= {s1_px_r, mid_eff, top_eff, win_r[5], win_r[4], win_r[3]};
    end
  end

  assign window = {s1_px_r, win_r[5], win_r[2],
                   mid_eff, win_r[4], win_r[1],
                   top_eff, win_r[3], win_r[0]};

  sgm_magnitude #(
    .COEF_BITS (COEF_BITS)
  ) u_magnitude (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s1_valid_r && s1_emit_r),
    .win       (window),
    .tag_in    (s1_tag_r),
    .kx        (kx_coefs),
    .ky        (ky_coefs),
    .out_valid (m_valid),
    .out_mag   (m_mag),
    .out_tag   (m_tag)
  );

  // output register plus skid register
  assign pop  = out_valid_r && out_ready;
  assign push = en && m_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        out_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_mag_r <= skid_mag_r;
        out_tag_r <= skid_tag_r;
      end
    end else if (push) begin
      if (out_valid_r && !pop) begin
        skid_mag_r <= m_mag;
        skid_tag_r <= m_tag;
      end else begin
        out_mag_r <= m_mag;
        out_tag_r <= m_tag;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_magnitude     = out_mag_r;
  assign out_col           = out_tag_r.col;
  assign out_row           = out_tag_r.row;
  assign out_last_of_image = out_tag_r.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid register full while output register empty");

  a_interior_only: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && s1_emit_r |-> (s1_tag_r.col != '0) && (s1_tag_r.row != '0))
    else $error("border position marked for output");

  a_row_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && row_end |=> col_cnt_r == '0)
    else $error("column counter did not wrap at end of row");

  a_image_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    accept && img_end |=> (row_cnt_r == '0) && (col_cnt_r == '0))
    else $error("position not cleared at end of image");

endmodule
